// ----- sv/lfc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types, codes and reset values of the LLDP frame and TLV checker.
// ----------------------------------------------------------------------------
package lfc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_DEST_MAC      = 3'd0;
	localparam logic [2:0] REG_ETHERTYPE     = 3'd1;
	localparam logic [2:0] REG_ORG_TLV_TYPE  = 3'd2;
	localparam logic [2:0] REG_DOT1_OUI      = 3'd3;
	localparam logic [2:0] REG_DOT3_OUI      = 3'd4;
	localparam logic [2:0] REG_CHASSIS_MAC   = 3'd5;
	localparam logic [2:0] REG_PORT_MAC      = 3'd6;

	// Configuration reset values
	localparam logic [47:0] RST_DEST_MAC     = 48'h0180_C200_000E;
	localparam logic [15:0] RST_ETHERTYPE    = 16'h88CC;
	localparam logic [6:0]  RST_ORG_TLV_TYPE = 7'd127;
	localparam logic [23:0] RST_DOT1_OUI     = 24'h0080C2;
	localparam logic [23:0] RST_DOT3_OUI     = 24'h00120F;
	localparam logic [7:0]  RST_CHASSIS_MAC  = 8'd4;
	localparam logic [7:0]  RST_PORT_MAC     = 8'd3;

	// Status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_MAC     = 3'd1;
	localparam logic [2:0] ST_BAD_ETYPE   = 3'd2;
	localparam logic [2:0] ST_TRUNCATED   = 3'd3;
	localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
	localparam logic [2:0] ST_UNK_TYPE    = 3'd5;
	localparam logic [2:0] ST_UNK_ORG     = 3'd6;
	localparam logic [2:0] ST_BAD_SUBTYPE = 3'd7;

	// Value kinds
	localparam logic [2:0] VK_NONE        = 3'd0;
	localparam logic [2:0] VK_CHASSIS_MAC = 3'd1;
	localparam logic [2:0] VK_PORT_MAC    = 3'd2;
	localparam logic [2:0] VK_TTL         = 3'd3;
	localparam logic [2:0] VK_CAPS        = 3'd4;
	localparam logic [2:0] VK_PVID        = 3'd5;
	localparam logic [2:0] VK_VLAN_ID     = 3'd6;

	// TLV types
	localparam logic [6:0] TLV_END       = 7'd0;
	localparam logic [6:0] TLV_CHASSIS   = 7'd1;
	localparam logic [6:0] TLV_PORT      = 7'd2;
	localparam logic [6:0] TLV_TTL       = 7'd3;
	localparam logic [6:0] TLV_PORT_DESC = 7'd4;
	localparam logic [6:0] TLV_SYS_NAME  = 7'd5;
	localparam logic [6:0] TLV_SYS_DESC  = 7'd6;
	localparam logic [6:0] TLV_CAPS      = 7'd7;
	localparam logic [6:0] TLV_MGMT_ADDR = 7'd8;

	// 802.1 organizational subtypes
	localparam logic [7:0] DOT1_PVID      = 8'd1;
	localparam logic [7:0] DOT1_PPVID     = 8'd2;
	localparam logic [7:0] DOT1_VLAN_NAME = 8'd3;
	localparam logic [7:0] DOT1_PROTO_ID  = 8'd4;

	// Ethernet header: MAC bytes, then source MAC, then ethertype
	localparam logic [3:0] HDR_MAC_BYTES  = 4'd6;
	localparam logic [3:0] HDR_ETYPE_HI   = 4'd12;

	typedef enum logic [3:0] {
		PH_HDR  = 4'b0001,
		PH_TLVH = 4'b0010,
		PH_VAL  = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [15:0] lldp_ethertype;
		logic [6:0]  org_tlv_type;
		logic [23:0] dot1_oui;
		logic [23:0] dot3_oui;
		logic [7:0]  chassis_mac_subtype;
		logic [7:0]  port_mac_subtype;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  tlv_type;
		logic [8:0]  tlv_length;
		logic [2:0]  value_kind;
		logic [47:0] value;
		logic        frame_done;
	} result_t;

endpackage

// ----- sv/lfc_ifs.sv -----
// ----------------------------------------------------------------------------
// lfc_ifs
// Valid/ready channels of the checker: frame bytes in, TLV reports out.
// ----------------------------------------------------------------------------
interface lfc_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface lfc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [6:0]  tlv_type;
	logic [8:0]  tlv_length;
	logic [2:0]  value_kind;
	logic [47:0] value;
	logic        frame_done;

	modport source (output valid, output status, output tlv_type, output tlv_length,
		output value_kind, output value, output frame_done, input ready);
	modport sink   (input valid, input status, input tlv_type, input tlv_length,
		input value_kind, input value, input frame_done, output ready);
endinterface

// ----- sv/lldp_frame_tlv_checker.sv -----
// ----------------------------------------------------------------------------
// lldp_frame_tlv_checker
// LLDP frame checker: validates the Ethernet header, walks TLVs and reports
// each TLV with a status and an extracted value.
// ----------------------------------------------------------------------------
// Usage:
//   frame  - one received byte per transaction, frame_last on the final byte.
//   report - at most one transaction per byte: type, length, status, value
//            kind and value of a finished TLV, or a header or truncation
//            error. frame_done marks a report made by the frame's last byte.
//   wr_en / wr_index / wr_data - configuration writes, taken on any edge
//            with wr_en high; write only while no frame is in flight.
// Throughput: one byte per cycle, sustained, with the report side ready.
// Flow: an accepted byte is registered in the input stage and parsed there;
//   its report loads into the output register when the byte leaves the
//   input stage, and is offered on the report side from that register.
// Stall: a byte that has a report to make waits in the input stage until
//   the output register can take it; a byte that makes no report moves on
//   regardless, so frame.ready only drops behind a held report.
// Reset: clears both stages, returns the parser to the start of a frame
//   and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module lldp_frame_tlv_checker import lfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lfc_frame_if.sink   frame,
	lfc_result_if.source report,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [47:0] wr_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    res;
	logic       emit;
	logic       out_free;
	logic       step;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_mac            <= RST_DEST_MAC;
			cfg_q.lldp_ethertype      <= RST_ETHERTYPE;
			cfg_q.org_tlv_type        <= RST_ORG_TLV_TYPE;
			cfg_q.dot1_oui            <= RST_DOT1_OUI;
			cfg_q.dot3_oui            <= RST_DOT3_OUI;
			cfg_q.chassis_mac_subtype <= RST_CHASSIS_MAC;
			cfg_q.port_mac_subtype    <= RST_PORT_MAC;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEST_MAC:     cfg_q.dest_mac            <= wr_data;
				REG_ETHERTYPE:    cfg_q.lldp_ethertype      <= wr_data[15:0];
				REG_ORG_TLV_TYPE: cfg_q.org_tlv_type        <= wr_data[6:0];
				REG_DOT1_OUI:     cfg_q.dot1_oui            <= wr_data[23:0];
				REG_DOT3_OUI:     cfg_q.dot3_oui            <= wr_data[23:0];
				REG_CHASSIS_MAC:  cfg_q.chassis_mac_subtype <= wr_data[7:0];
				REG_PORT_MAC:     cfg_q.port_mac_subtype    <= wr_data[7:0];
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	// The output register is free when empty or being drained this cycle.
	assign out_free    = !out_valid_q || report.ready;
	// Advance the input stage unless its report would overwrite a held one.
	assign step        = valid_s1 && (out_free || !emit);
	assign frame.ready = !valid_s1 || step;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.data_byte;
			last_s1 <= frame.frame_last;
		end
	end

	lfc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (valid_s1),
		.data_byte  (byte_s1),
		.frame_last (last_s1),
		.advance    (step),
		.emit       (emit),
		.res        (res)
	);

	// Output register: load a fresh report, otherwise drop the taken one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) out_q <= res;
	end

	assign report.valid      = out_valid_q;
	assign report.status     = out_q.status;
	assign report.tlv_type   = out_q.tlv_type;
	assign report.tlv_length = out_q.tlv_length;
	assign report.value_kind = out_q.value_kind;
	assign report.value      = out_q.value;
	assign report.frame_done = out_q.frame_done;

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |-> emit && out_valid_q && !report.ready)
		else $error("input stage held without a blocked report");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready |=> valid_s1)
		else $error("accepted byte lost before parsing");

	a_report_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> report.valid)
		else $error("parsed report did not reach the output register");

endmodule

// ----- sv/lfc_eval.sv -----
// ----------------------------------------------------------------------------
// lfc_eval
// Length, OUI and subtype rules of one completed TLV; picks the value.
// ----------------------------------------------------------------------------
module lfc_eval import lfc_pkg::*; (
	input  cfg_t        cfg,
	input  logic [6:0]  typ,
	input  logic [8:0]  len,
	input  logic [23:0] oui,
	input  logic [7:0]  subtype,
	input  logic [7:0]  vname_len,
	input  logic [47:0] val,
	output logic [2:0]  status,
	output logic [2:0]  kind,
	output logic [47:0] value
);

	logic [9:0] vname_end;

	assign vname_end = 10'd7 + {2'b00, vname_len};

	always_comb begin
		status = ST_OK;
		kind   = VK_NONE;
		value  = '0;
		if (typ == cfg.org_tlv_type) begin
			if (len < 9'd3) begin
				status = ST_BAD_LENGTH;
			end else if (oui == cfg.dot1_oui) begin
				if (len < 9'd4) begin
					status = ST_BAD_LENGTH;
				end else begin
					case (subtype) inside
						DOT1_PPVID, DOT1_PROTO_ID: status = ST_OK;
						DOT1_PVID: begin
							if (len < 9'd6) begin
								status = ST_BAD_LENGTH;
							end else begin
								kind  = VK_PVID;
								value = {32'd0, val[15:0]};
							end
						end
						DOT1_VLAN_NAME: begin
							if (len < 9'd7 || {1'b0, len} < vname_end) begin
								status = ST_BAD_LENGTH;
							end else begin
								kind  = VK_VLAN_ID;
								value = {32'd0, val[15:0]};
							end
						end
						default: status = ST_BAD_SUBTYPE;
					endcase
				end
			end else if (oui != cfg.dot3_oui) begin
				status = ST_UNK_ORG;
			end
		end else begin
			case (typ) inside
				TLV_END: begin
					if (len != 9'd0) status = ST_BAD_LENGTH;
				end
				TLV_CHASSIS, TLV_PORT: begin
					if (len < 9'd2) begin
						status = ST_BAD_LENGTH;
					end else if (subtype == ((typ == TLV_CHASSIS) ? cfg.chassis_mac_subtype
							: cfg.port_mac_subtype)) begin
						if (len != 9'd7) begin
							status = ST_BAD_LENGTH;
						end else begin
							kind  = (typ == TLV_CHASSIS) ? VK_CHASSIS_MAC : VK_PORT_MAC;
							value = val;
						end
					end
				end
				TLV_TTL: begin
					if (len != 9'd2) begin
						status = ST_BAD_LENGTH;
					end else begin
						kind  = VK_TTL;
						value = {32'd0, val[15:0]};
					end
				end
				TLV_PORT_DESC, TLV_SYS_NAME, TLV_SYS_DESC: begin
					if (len == 9'd0) status = ST_BAD_LENGTH;
				end
				TLV_CAPS: begin
					if (len != 9'd4) begin
						status = ST_BAD_LENGTH;
					end else begin
						kind  = VK_CAPS;
						value = {16'd0, val[31:0]};
					end
				end
				TLV_MGMT_ADDR: status = ST_OK;
				default: status = ST_UNK_TYPE;
			endcase
		end
	end

endmodule

// ----- sv/lfc_parser.sv -----
// ----------------------------------------------------------------------------
// lfc_parser
// Frame walker: header check, TLV header and value capture, skip on error.
// ----------------------------------------------------------------------------
module lfc_parser import lfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       byte_valid,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	input  logic       advance,
	output logic       emit,
	output result_t    res
);

	phase_t      phase_q, n_phase;
	logic [3:0]  hdr_cnt_q, n_hdr_cnt;
	logic        etype_hi_ok_q, n_etype_hi_ok;
	logic [8:0]  cnt_q, n_cnt, cnt_inc;
	logic [6:0]  cur_type_q, n_type;
	logic [8:0]  cur_len_q, n_len;
	logic [23:0] oui_q, n_oui;
	logic [7:0]  subtype_q, n_subtype;
	logic [7:0]  vname_len_q, n_vname_len;
	logic [47:0] val_q, n_val;
	logic [2:0]  mac_sel;
	logic [7:0]  mac_byte;
	logic        is_org;
	logic [2:0]  ev_status;
	logic [2:0]  ev_kind;
	logic [47:0] ev_value;

	assign is_org   = (cur_type_q == cfg.org_tlv_type);
	assign cnt_inc  = cnt_q + 9'd1;
	assign mac_sel  = 3'd5 - hdr_cnt_q[2:0];
	assign mac_byte = cfg.dest_mac[{mac_sel, 3'b000} +: 8];

	// TLV field capture
	always_comb begin
		n_type      = cur_type_q;
		n_len       = cur_len_q;
		n_oui       = oui_q;
		n_subtype   = subtype_q;
		n_vname_len = vname_len_q;
		n_val       = val_q;
		if (phase_q == PH_TLVH) begin
			if (cnt_q == 9'd0) begin
				n_type      = data_byte[7:1];
				n_len       = {data_byte[0], 8'h00};
				n_oui       = '0;
				n_subtype   = '0;
				n_vname_len = '0;
				n_val       = '0;
			end else begin
				n_len = cur_len_q | {1'b0, data_byte};
			end
		end else if (phase_q == PH_VAL) begin
			if (is_org) begin
				if (cnt_q < 9'd3) begin
					n_oui = {oui_q[15:0], data_byte};
				end else if (cnt_q == 9'd3) begin
					n_subtype = data_byte;
				end else if (cnt_q == 9'd4 || cnt_q == 9'd5) begin
					n_val = {val_q[39:0], data_byte};
				end else if (cnt_q == 9'd6) begin
					n_vname_len = data_byte;
				end
			end else begin
				if (cnt_q == 9'd0) n_subtype = data_byte;
				n_val = {val_q[39:0], data_byte};
			end
		end
	end

	lfc_eval u_eval (
		.cfg       (cfg),
		.typ       (n_type),
		.len       (n_len),
		.oui       (n_oui),
		.subtype   (n_subtype),
		.vname_len (n_vname_len),
		.val       (n_val),
		.status    (ev_status),
		.kind      (ev_kind),
		.value     (ev_value)
	);

	// Sequencing and result selection
	always_comb begin
		n_phase       = phase_q;
		n_hdr_cnt     = hdr_cnt_q;
		n_etype_hi_ok = etype_hi_ok_q;
		n_cnt         = cnt_q;
		emit          = 1'b0;
		res           = '{status: ST_TRUNCATED, tlv_type: n_type, tlv_length: n_len,
			value_kind: VK_NONE, value: '0, frame_done: frame_last};
		unique case (phase_q)
			PH_HDR: begin
				if (hdr_cnt_q < HDR_MAC_BYTES) begin
					if (data_byte != mac_byte || frame_last) begin
						emit = 1'b1;
						res  = '{status: ((data_byte != mac_byte || hdr_cnt_q < 4'd5) ?
							ST_BAD_MAC : ST_BAD_ETYPE), tlv_type: '0, tlv_length: '0,
							value_kind: VK_NONE, value: '0, frame_done: frame_last};
					end else begin
						n_hdr_cnt = hdr_cnt_q + 4'd1;
					end
				end else if (hdr_cnt_q < HDR_ETYPE_HI) begin
					if (frame_last) begin
						emit = 1'b1;
						res  = '{status: ST_BAD_ETYPE, tlv_type: '0, tlv_length: '0,
							value_kind: VK_NONE, value: '0, frame_done: 1'b1};
					end else begin
						n_hdr_cnt = hdr_cnt_q + 4'd1;
					end
				end else if (hdr_cnt_q == HDR_ETYPE_HI) begin
					n_etype_hi_ok = (data_byte == cfg.lldp_ethertype[15:8]);
					if (frame_last) begin
						emit = 1'b1;
						res  = '{status: ST_BAD_ETYPE, tlv_type: '0, tlv_length: '0,
							value_kind: VK_NONE, value: '0, frame_done: 1'b1};
					end else begin
						n_hdr_cnt = HDR_ETYPE_HI + 4'd1;
					end
				end else begin
					if (!(etype_hi_ok_q && data_byte == cfg.lldp_ethertype[7:0])) begin
						emit = 1'b1;
						res  = '{status: ST_BAD_ETYPE, tlv_type: '0, tlv_length: '0,
							value_kind: VK_NONE, value: '0, frame_done: frame_last};
					end else if (!frame_last) begin
						n_phase = PH_TLVH;
						n_cnt   = '0;
					end
				end
				// header errors skip the rest of the frame
				if (emit && !frame_last) n_phase = PH_SKIP;
			end
			PH_TLVH: begin
				if (cnt_q == 9'd0) begin
					if (frame_last) begin
						emit = 1'b1;
					end else begin
						n_cnt = 9'd1;
					end
				end else if (n_len == 9'd0) begin
					emit = 1'b1;
					res  = '{status: ev_status, tlv_type: n_type, tlv_length: n_len,
						value_kind: ev_kind, value: ev_value, frame_done: frame_last};
					n_phase = (ev_status != ST_OK) ? PH_SKIP : PH_TLVH;
					n_cnt   = '0;
				end else begin
					n_phase = PH_VAL;
					n_cnt   = '0;
					emit    = frame_last;
				end
			end
			PH_VAL: begin
				n_cnt = cnt_inc;
				if (cnt_inc >= cur_len_q) begin
					emit = 1'b1;
					res  = '{status: ev_status, tlv_type: n_type, tlv_length: n_len,
						value_kind: ev_kind, value: ev_value, frame_done: frame_last};
					n_phase = (ev_status != ST_OK) ? PH_SKIP : PH_TLVH;
					n_cnt   = '0;
				end else begin
					emit = frame_last;
				end
			end
			PH_SKIP: begin
				n_phase = PH_SKIP;
			end
			default: begin
				n_phase = PH_HDR;
			end
		endcase
		// the last byte always closes the frame
		if (frame_last) begin
			n_phase       = PH_HDR;
			n_hdr_cnt     = '0;
			n_etype_hi_ok = 1'b0;
			n_cnt         = '0;
		end
		if (!byte_valid) emit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR;
			hdr_cnt_q     <= '0;
			etype_hi_ok_q <= 1'b0;
			cnt_q         <= '0;
			cur_type_q    <= '0;
			cur_len_q     <= '0;
			oui_q         <= '0;
			subtype_q     <= '0;
			vname_len_q   <= '0;
			val_q         <= '0;
		end else if (advance) begin
			phase_q       <= n_phase;
			hdr_cnt_q     <= n_hdr_cnt;
			etype_hi_ok_q <= n_etype_hi_ok;
			cnt_q         <= n_cnt;
			cur_type_q    <= n_type;
			cur_len_q     <= n_len;
			oui_q         <= n_oui;
			subtype_q     <= n_subtype;
			vname_len_q   <= n_vname_len;
			val_q         <= n_val;
		end
	end

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> !emit)
		else $error("report raised while skipping a frame");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.value_kind != VK_NONE |-> res.status == ST_OK)
		else $error("value reported with an error status");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && frame_last |=> phase_q == PH_HDR && hdr_cnt_q == 4'd0)
		else $error("frame end did not restart header parsing");

endmodule
